// ===== rtl/uart_register_file_with_divisor_latch_defines.svh =====
//-----------------------------------------------------------------------------
// UART register file assertion macros
// Shared macros for the concurrent checks on the register file ports.
//-----------------------------------------------------------------------------
`ifndef UART_REGISTER_FILE_WITH_DIVISOR_LATCH_DEFINES_SVH
`define UART_REGISTER_FILE_WITH_DIVISOR_LATCH_DEFINES_SVH

// Check that is ignored while reset is high.
`define URF_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check that also holds while reset is high.
`define URF_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/urf_pkg.sv =====
//-----------------------------------------------------------------------------
// UART register file package
// Types, field widths and register codes shared by the register file modules.
//-----------------------------------------------------------------------------
package urf_pkg;

   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 40;

   typedef enum logic [1:0] {
      CMD_READ  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_RX    = 2'd2,
      CMD_TX    = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      REG_DATA = 3'd0,
      REG_IER  = 3'd1,
      REG_IIR  = 3'd2,
      REG_LCR  = 3'd3,
      REG_MCR  = 3'd4,
      REG_LSR  = 3'd5,
      REG_MSR  = 3'd6,
      REG_SCR  = 3'd7
   } offset_type;

   localparam int DLAB_BIT = 7;
   localparam int OUT2_BIT = 3;

   localparam logic [7:0] IIR_LINE_STATUS = 8'h06;
   localparam logic [7:0] IIR_RX_DATA     = 8'h04;
   localparam logic [7:0] IIR_TX_EMPTY    = 8'h02;
   localparam logic [7:0] IIR_NONE        = 8'h01;
   localparam logic [7:0] IIR_FIFO_BITS   = 8'hC0;

   typedef struct packed {
      cmd_type    cmd;
      offset_type reg_offset;
      logic [7:0] write_data;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic        tx_valid;
      logic [7:0]  tx_byte;
      logic        irq_pending;
      logic [15:0] baud_divisor;
      logic [6:0]  line_format;
   } rsp_type;

endpackage

// ===== rtl/uart_register_file_with_divisor_latch.sv =====
//-----------------------------------------------------------------------------
// UART register file with divisor latch
// 16550-style register file driven by bus accesses and line events.
//-----------------------------------------------------------------------------
// Each request transfer is one bus read, bus write, received byte or transmit
// take, and yields exactly one response transfer. A request is registered, the
// register file is updated by one level of decode logic, and the response is
// registered. One transfer is taken every cycle while the response side keeps
// up; a stalled response holds the one request already registered behind it.
module uart_register_file_with_divisor_latch
   import urf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // reg_offset, write_data, rx_byte
   input  logic [1:0]             req_tuser,  // cmd
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // read_data, tx_byte, irq_pending,
                                              // baud_divisor, line_format
   output logic                   rsp_tuser   // tx_valid
);

   logic    item_valid;
   logic    result_ready;
   logic    fire;
   req_type item;
   rsp_type result;

   assign fire = item_valid && result_ready;

   urf_req_stage u_req_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .item_valid (item_valid),
      .item_take  (fire),
      .item       (item)
   );

   urf_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (item),
      .result (result)
   );

   urf_rsp_stage u_rsp_stage (
      .clock        (clock),
      .reset        (reset),
      .result_valid (item_valid),
      .result_ready (result_ready),
      .result       (result),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser)
   );

endmodule

// ===== rtl/urf_req_stage.sv =====
//-----------------------------------------------------------------------------
// UART register file request stage
// Input register that captures one request transfer and unpacks its fields.
//-----------------------------------------------------------------------------
module urf_req_stage
   import urf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic [1:0]             req_tuser,
   output logic                   item_valid,
   input  logic                   item_take,
   output req_type                item
);

   logic    valid_ff;
   logic    valid_in;
   req_type item_ff;
   req_type item_in;
   logic    load;

   assign req_tready = !valid_ff || item_take;
   assign load       = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      if (item_take) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
      end
      item_in.cmd        = cmd_type'(req_tuser);
      item_in.reg_offset = offset_type'(req_tdata[2:0]);
      item_in.write_data = req_tdata[10:3];
      item_in.rx_byte    = req_tdata[18:11];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== rtl/urf_core.sv =====
//-----------------------------------------------------------------------------
// UART register file core
// Register state, banked bus decode, holder handshakes and interrupt logic.
//-----------------------------------------------------------------------------
module urf_core
   import urf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    fire,
   input  req_type item,
   output rsp_type result
);

   logic [7:0]  lcr_ff, lcr_in;
   logic [3:0]  ier_ff, ier_in;
   logic [4:0]  mcr_ff, mcr_in;
   logic        fen_ff, fen_in;
   logic [15:0] div_ff, div_in;
   logic [7:0]  scr_ff, scr_in;
   logic [7:0]  thr_ff, thr_in;
   logic        thre_ff, thre_in;
   logic [7:0]  rbr_ff, rbr_in;
   logic        dr_ff, dr_in;
   logic        oe_ff, oe_in;
   logic        dlab;
   logic [7:0]  ident;
   logic [7:0]  rd;
   logic        txv;
   logic [7:0]  txb;
   logic        irq;

   assign dlab = lcr_ff[DLAB_BIT];

   always_comb begin
      priority if (ier_ff[2] && oe_ff) begin
         ident = IIR_LINE_STATUS;
      end else if (ier_ff[0] && dr_ff) begin
         ident = IIR_RX_DATA;
      end else if (ier_ff[1] && thre_ff) begin
         ident = IIR_TX_EMPTY;
      end else begin
         ident = IIR_NONE;
      end
      if (fen_ff) begin
         ident = ident | IIR_FIFO_BITS;
      end
   end

   always_comb begin
      lcr_in  = lcr_ff;
      ier_in  = ier_ff;
      mcr_in  = mcr_ff;
      fen_in  = fen_ff;
      div_in  = div_ff;
      scr_in  = scr_ff;
      thr_in  = thr_ff;
      thre_in = thre_ff;
      rbr_in  = rbr_ff;
      dr_in   = dr_ff;
      oe_in   = oe_ff;
      rd      = 8'd0;
      txv     = 1'b0;
      txb     = 8'd0;
      unique case (item.cmd)
         CMD_READ: begin
            unique case (item.reg_offset)
               REG_DATA: begin
                  if (dlab) begin
                     rd = div_ff[7:0];
                  end else begin
                     rd    = rbr_ff;
                     dr_in = 1'b0;
                  end
               end
               REG_IER: rd = dlab ? div_ff[15:8] : {4'd0, ier_ff};
               REG_IIR: rd = ident;
               REG_LCR: rd = lcr_ff;
               REG_MCR: rd = {3'd0, mcr_ff};
               REG_LSR: begin
                  rd    = {1'b0, thre_ff, thre_ff, 3'd0, oe_ff, dr_ff};
                  oe_in = 1'b0;
               end
               REG_MSR: rd = 8'd0;
               REG_SCR: rd = scr_ff;
            endcase
         end
         CMD_WRITE: begin
            unique case (item.reg_offset)
               REG_DATA: begin
                  if (dlab) begin
                     div_in = {div_ff[15:8], item.write_data};
                  end else begin
                     thr_in  = item.write_data;
                     thre_in = 1'b0;
                  end
               end
               REG_IER: begin
                  if (dlab) begin
                     div_in = {item.write_data, div_ff[7:0]};
                  end else begin
                     ier_in = item.write_data[3:0];
                  end
               end
               REG_IIR: begin
                  fen_in = item.write_data[0];
                  if (item.write_data[0]) begin
                     if (item.write_data[1]) begin
                        dr_in = 1'b0;
                     end
                     if (item.write_data[2]) begin
                        thre_in = 1'b1;
                     end
                  end
               end
               REG_LCR: lcr_in = item.write_data;
               REG_MCR: mcr_in = item.write_data[4:0];
               REG_SCR: scr_in = item.write_data;
               default: begin
               end
            endcase
         end
         CMD_RX: begin
            if (dr_ff) begin
               oe_in = 1'b1;
            end
            rbr_in = item.rx_byte;
            dr_in  = 1'b1;
         end
         CMD_TX: begin
            if (!thre_ff) begin
               txv     = 1'b1;
               txb     = thr_ff;
               thre_in = 1'b1;
            end
         end
      endcase
      irq = ((ier_in[2] && oe_in) || (ier_in[0] && dr_in) || (ier_in[1] && thre_in))
            && mcr_in[OUT2_BIT];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lcr_ff  <= 8'd0;
         ier_ff  <= 4'd0;
         mcr_ff  <= 5'd0;
         fen_ff  <= 1'b0;
         div_ff  <= 16'd0;
         scr_ff  <= 8'd0;
         thr_ff  <= 8'd0;
         thre_ff <= 1'b1;
         rbr_ff  <= 8'd0;
         dr_ff   <= 1'b0;
         oe_ff   <= 1'b0;
      end else if (fire) begin
         lcr_ff  <= lcr_in;
         ier_ff  <= ier_in;
         mcr_ff  <= mcr_in;
         fen_ff  <= fen_in;
         div_ff  <= div_in;
         scr_ff  <= scr_in;
         thr_ff  <= thr_in;
         thre_ff <= thre_in;
         rbr_ff  <= rbr_in;
         dr_ff   <= dr_in;
         oe_ff   <= oe_in;
      end
   end

   assign result.read_data    = rd;
   assign result.tx_valid     = txv;
   assign result.tx_byte      = txb;
   assign result.irq_pending  = irq;
   assign result.baud_divisor = div_in;
   assign result.line_format  = lcr_in[6:0];

endmodule

// ===== rtl/urf_rsp_stage.sv =====
//-----------------------------------------------------------------------------
// UART register file response stage
// Result register that holds one response until the consumer takes it.
//-----------------------------------------------------------------------------
module urf_rsp_stage
   import urf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   result_valid,
   output logic                   result_ready,
   input  rsp_type                result,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tuser
);

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;
   logic    load;

   assign result_ready = !valid_ff || rsp_tready;
   assign load         = result_valid && result_ready;

   always_comb begin
      valid_in = valid_ff;
      if (rsp_tready) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = data_ff.tx_valid;
   assign rsp_tdata  = {data_ff.line_format, data_ff.baud_divisor, data_ff.irq_pending,
                        data_ff.tx_byte, data_ff.read_data};

endmodule

// ===== rtl/urf_checker.sv =====
//-----------------------------------------------------------------------------
// UART register file checker
// Port-level checks on the response channel, bound to the top level.
//-----------------------------------------------------------------------------
`include "uart_register_file_with_divisor_latch_defines.svh"

module urf_checker
   import urf_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic                   rsp_tuser
);

   `URF_ASSERT(a_rsp_hold_valid, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "response dropped while stalled")
   `URF_ASSERT(a_rsp_hold_data, rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser), "response changed while stalled")
   `URF_ASSERT(a_tx_byte_zero, rsp_tvalid && !rsp_tuser |-> rsp_tdata[15:8] == 8'd0, "transmit byte without transmit transfer")
   `URF_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_tvalid, "response valid after reset")

endmodule

bind uart_register_file_with_divisor_latch urf_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== verif/uart_register_file_with_divisor_latch_test.sv =====
//-----------------------------------------------------------------------------
// UART register file with divisor latch: self-checking testbench
// Bus reads and writes, received bytes and transmit takes are sent as request
// transfers. A behavioral model of the register file predicts every response,
// and each response transfer is checked field by field against the oldest
// prediction. Both sides idle and stall at random except in the last phase.
//-----------------------------------------------------------------------------
module uart_register_file_with_divisor_latch_test;
   import urf_pkg::*;

   localparam int QUIET_LIMIT = 500;
   localparam int DRAIN_CYCLES = 4;

   localparam int IER_RX_DATA = 0;
   localparam int IER_TX_EMPTY = 1;
   localparam int IER_LINE_STATUS = 2;
   localparam int FCR_ENABLE = 0;
   localparam int FCR_CLEAR_RX = 1;
   localparam int FCR_CLEAR_TX = 2;
   localparam logic [7:0] LSR_DATA_READY = 8'h01;
   localparam logic [7:0] LSR_OVERRUN = 8'h02;
   localparam logic [7:0] LSR_THR_EMPTY = 8'h20;
   localparam logic [7:0] LSR_TX_IDLE = 8'h40;

   typedef struct packed {
      logic [7:0]  read_data;
      logic        tx_valid;
      logic [7:0]  tx_byte;
      logic        irq_pending;
      logic [15:0] baud_divisor;
      logic [6:0]  line_format;
   } reply_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;  // reg_offset, write_data, rx_byte
   logic [1:0]             req_tuser;  // cmd
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;  // read_data, tx_byte, irq_pending,
                                       // baud_divisor, line_format
   logic                   rsp_tuser;  // tx_valid

   logic [7:0]  lcr_q;
   logic [3:0]  ier_q;
   logic [4:0]  mcr_q;
   logic        fifo_on;
   logic [15:0] dl_q;
   logic [7:0]  scr_q;
   logic [7:0]  thr_q;
   logic        thr_empty;
   logic [7:0]  rbr_q;
   logic        rx_ready;
   logic        rx_overrun;

   reply_type pending_replies[$];
   int        sent_count[4];
   int        checked_count;
   int        error_count;
   int        quiet_cycles;
   bit        gaps_enable;
   bit        stall_enable;

   uart_register_file_with_divisor_latch dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [7:0] interrupt_id();
      logic [7:0] code;
      if (ier_q[IER_LINE_STATUS] && rx_overrun) begin
         code = IIR_LINE_STATUS;
      end else if (ier_q[IER_RX_DATA] && rx_ready) begin
         code = IIR_RX_DATA;
      end else if (ier_q[IER_TX_EMPTY] && thr_empty) begin
         code = IIR_TX_EMPTY;
      end else begin
         code = IIR_NONE;
      end
      if (fifo_on) begin
         code = code | IIR_FIFO_BITS;
      end
      return code;
   endfunction

   task automatic apply_transfer(input cmd_type c, input offset_type off,
                                 input logic [7:0] wd, input logic [7:0] rb,
                                 output reply_type r);
      logic dlab;
      dlab = lcr_q[DLAB_BIT];
      r = '0;
      case (c)
         CMD_READ: begin
            case (off)
               REG_DATA: begin
                  if (dlab) begin
                     r.read_data = dl_q[7:0];
                  end else begin
                     r.read_data = rbr_q;
                     rx_ready = 1'b0;
                  end
               end
               REG_IER: r.read_data = dlab ? dl_q[15:8] : {4'b0, ier_q};
               REG_IIR: r.read_data = interrupt_id();
               REG_LCR: r.read_data = lcr_q;
               REG_MCR: r.read_data = {3'b0, mcr_q};
               REG_LSR: begin
                  r.read_data = (rx_ready ? LSR_DATA_READY : 8'h00)
                              | (rx_overrun ? LSR_OVERRUN : 8'h00)
                              | (thr_empty ? (LSR_THR_EMPTY | LSR_TX_IDLE) : 8'h00);
                  rx_overrun = 1'b0;
               end
               REG_MSR: r.read_data = 8'h00;
               default: r.read_data = scr_q;
            endcase
         end
         CMD_WRITE: begin
            case (off)
               REG_DATA: begin
                  if (dlab) begin
                     dl_q[7:0] = wd;
                  end else begin
                     thr_q = wd;
                     thr_empty = 1'b0;
                  end
               end
               REG_IER: begin
                  if (dlab) begin
                     dl_q[15:8] = wd;
                  end else begin
                     ier_q = wd[3:0];
                  end
               end
               REG_IIR: begin
                  fifo_on = wd[FCR_ENABLE];
                  if (wd[FCR_ENABLE] && wd[FCR_CLEAR_RX]) begin
                     rx_ready = 1'b0;
                  end
                  if (wd[FCR_ENABLE] && wd[FCR_CLEAR_TX]) begin
                     thr_empty = 1'b1;
                  end
               end
               REG_LCR: lcr_q = wd;
               REG_MCR: mcr_q = wd[4:0];
               REG_SCR: scr_q = wd;
               default: ;
            endcase
         end
         CMD_RX: begin
            if (rx_ready) begin
               rx_overrun = 1'b1;
            end
            rbr_q = rb;
            rx_ready = 1'b1;
         end
         default: begin
            if (!thr_empty) begin
               r.tx_valid = 1'b1;
               r.tx_byte = thr_q;
               thr_empty = 1'b1;
            end
         end
      endcase
      r.irq_pending = (interrupt_id() & 8'h0F) != IIR_NONE && mcr_q[OUT2_BIT];
      r.baud_divisor = dl_q;
      r.line_format = lcr_q[6:0];
   endtask

   task automatic send_transfer(input cmd_type c, input offset_type off,
                                input logic [7:0] wd, input logic [7:0] rb);
      reply_type r;
      if (gaps_enable && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {5'b0, rb, wd, off};
      req_tuser <= c;
      do @(posedge clock); while (!req_tready);
      apply_transfer(c, off, wd, rb, r);
      pending_replies.push_back(r);
      sent_count[int'(c)]++;
   endtask

   task automatic wait_for_replies();
      req_tvalid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
   endtask

   task automatic test_reset_state();
      send_transfer(CMD_READ, REG_IIR, 8'h00, 8'h00);
      send_transfer(CMD_READ, REG_LSR, 8'h00, 8'h00);
      send_transfer(CMD_READ, REG_MSR, 8'h00, 8'h00);
      send_transfer(CMD_READ, REG_DATA, 8'h00, 8'h00);
   endtask

   task automatic test_divisor_latch();
      send_transfer(CMD_WRITE, REG_LCR, 8'h80, 8'h00);
      send_transfer(CMD_WRITE, REG_DATA, 8'hFF, 8'h00);
      send_transfer(CMD_WRITE, REG_IER, 8'hFF, 8'hFF);
      send_transfer(CMD_READ, REG_DATA, 8'h00, 8'h00);
      send_transfer(CMD_READ, REG_IER, 8'h00, 8'h00);
      send_transfer(CMD_WRITE, REG_LCR, 8'h7F, 8'h00);
      send_transfer(CMD_READ, REG_LCR, 8'h00, 8'h00);
   endtask

   task automatic test_receive_path();
      send_transfer(CMD_WRITE, REG_IER, 8'hFF, 8'h00);
      send_transfer(CMD_WRITE, REG_MCR, 8'hFF, 8'h00);
      send_transfer(CMD_RX, REG_DATA, 8'h00, 8'h00);
      send_transfer(CMD_RX, REG_SCR, 8'hFF, 8'hFF);
      send_transfer(CMD_READ, REG_IIR, 8'h00, 8'h00);
      send_transfer(CMD_READ, REG_LSR, 8'h00, 8'h00);
      send_transfer(CMD_READ, REG_DATA, 8'h00, 8'h00);
      send_transfer(CMD_READ, REG_DATA, 8'h00, 8'h00);
   endtask

   task automatic test_transmit_path();
      send_transfer(CMD_TX, REG_DATA, 8'h00, 8'h00);
      send_transfer(CMD_WRITE, REG_DATA, 8'hA5, 8'h00);
      send_transfer(CMD_WRITE, REG_DATA, 8'h5A, 8'h00);
      send_transfer(CMD_TX, REG_DATA, 8'h00, 8'h00);
      send_transfer(CMD_WRITE, REG_DATA, 8'h3C, 8'h00);
      send_transfer(CMD_WRITE, REG_IIR, 8'h07, 8'h00);
      send_transfer(CMD_WRITE, REG_IIR, 8'h06, 8'h00);
      send_transfer(CMD_WRITE, REG_LSR, 8'hFF, 8'h00);
      send_transfer(CMD_WRITE, REG_MSR, 8'hFF, 8'h00);
      send_transfer(CMD_WRITE, REG_SCR, 8'hFF, 8'h00);
      send_transfer(CMD_READ, REG_SCR, 8'h00, 8'h00);
      send_transfer(CMD_READ, REG_MCR, 8'h00, 8'h00);
   endtask

   task automatic test_random_traffic(input int count);
      cmd_type    c;
      offset_type off;
      int         pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            c = CMD_READ;
         end else if (pick < 70) begin
            c = CMD_WRITE;
         end else if (pick < 85) begin
            c = CMD_RX;
         end else begin
            c = CMD_TX;
         end
         off = offset_type'($urandom_range(0, 7));
         send_transfer(c, off, 8'($urandom), 8'($urandom));
      end
   endtask

   function automatic void check_field(string name, int unsigned expv, int unsigned actv);
      if (expv != actv) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, expv, actv);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      reply_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_replies.size() == 0) begin
            $error("Response transfer arrived with no prediction pending.");
            error_count++;
         end else begin
            want = pending_replies.pop_front();
            check_field("read_data", want.read_data, rsp_tdata[7:0]);
            check_field("tx_valid", want.tx_valid, rsp_tuser);
            check_field("tx_byte", want.tx_byte, rsp_tdata[15:8]);
            check_field("irq_pending", want.irq_pending, rsp_tdata[16]);
            check_field("baud_divisor", want.baud_divisor, rsp_tdata[32:17]);
            check_field("line_format", want.line_format, rsp_tdata[39:33]);
            checked_count++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (!req_tvalid && pending_replies.size() == 0)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Timeout: no transfer for %0d cycles.", QUIET_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      rsp_tready <= 1'b1;
      forever begin
         @(posedge clock);
         if (stall_enable && !reset && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= CMD_READ;
      lcr_q = '0;
      ier_q = '0;
      mcr_q = '0;
      fifo_on = 1'b0;
      dl_q = '0;
      scr_q = '0;
      thr_q = '0;
      thr_empty = 1'b1;
      rbr_q = '0;
      rx_ready = 1'b0;
      rx_overrun = 1'b0;
      gaps_enable = 1'b1;
      stall_enable = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_divisor_latch();
      test_receive_path();
      test_transmit_path();
      test_random_traffic(150);
      wait_for_replies();
      test_random_traffic(150);
      gaps_enable = 1'b0;
      stall_enable = 1'b0;
      test_random_traffic(100);

      req_tvalid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d reads, %0d writes, %0d received bytes and %0d transmit takes.",
               sent_count[CMD_READ], sent_count[CMD_WRITE], sent_count[CMD_RX],
               sent_count[CMD_TX]);
      $display("Checked %0d responses under random idling and back-pressure.",
               checked_count);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/urf_pkg.sv
rtl/urf_req_stage.sv
rtl/urf_core.sv
rtl/urf_rsp_stage.sv
rtl/uart_register_file_with_divisor_latch.sv
rtl/urf_checker.sv
verif/uart_register_file_with_divisor_latch_test.sv
